>>> hw/rtl/sis_pkg.sv
// Shared constants, codes and the command type of the subset index sampler.
package sis_pkg;

	// Default sizing of the block.
	localparam int SIS_MAX_POINTS = 4096;
	localparam int SIS_MAX_SUBSET = 8;

	// Repeat counter: width, saturation value and the limit past which a duplicate is forced.
	localparam int             REP_W        = 7;
	localparam logic [REP_W-1:0] REPEAT_LIMIT = 7'd100;
	localparam logic [REP_W-1:0] REPEAT_SAT   = 7'd127;

	// Configuration register indexes.
	localparam int         CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_ENUMERATE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_POINTS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SUBSET_SIZE = 2'd2;

	// Result status codes.
	localparam int         STS_W = 2;
	localparam logic [STS_W-1:0] STS_NORMAL    = 2'd0;
	localparam logic [STS_W-1:0] STS_EXHAUSTED = 2'd1;
	localparam logic [STS_W-1:0] STS_FORCED    = 2'd2;

	// Command codes passed from the front end to the back end.
	localparam int         OP_W = 3;
	localparam logic [OP_W-1:0] OP_ENUM_START = 3'd0;
	localparam logic [OP_W-1:0] OP_ENUM_EMPTY = 3'd1;
	localparam logic [OP_W-1:0] OP_ENUM_NEXT  = 3'd2;
	localparam logic [OP_W-1:0] OP_RAND_ONE   = 3'd3;
	localparam logic [OP_W-1:0] OP_RAND_DROP  = 3'd4;
	localparam logic [OP_W-1:0] OP_RAND_CAND  = 3'd5;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            start;
	} cmd_t;

endpackage

>>> hw/rtl/sis_front.sv
// Front end: accepts input beats and classifies them into back-end commands.
module sis_front #(
	parameter int MAX_POINTS = sis_pkg::SIS_MAX_POINTS,
	parameter int MAX_SUBSET = sis_pkg::SIS_MAX_SUBSET,
	localparam int PTS_W  = $clog2(MAX_POINTS + 1),
	localparam int CAND_W = $clog2(MAX_POINTS),
	localparam int K_W    = $clog2(MAX_SUBSET + 1)
) (
	input  logic               item_valid,
	output logic               item_ready,
	input  logic               start_req,
	input  logic [CAND_W-1:0]  candidate,
	input  logic               enum_mode,
	input  logic [PTS_W-1:0]   eff_n,
	input  logic [K_W-1:0]     eff_k,
	input  logic               q_full,
	output logic               push,
	output sis_pkg::cmd_t      push_cmd,
	output logic [CAND_W-1:0]  push_cand
);
	import sis_pkg::*;

	logic k_over_n;

	assign item_ready = !q_full;
	assign push       = item_valid && !q_full;
	assign push_cand  = candidate;
	assign k_over_n   = (PTS_W + K_W)'(eff_k) > (PTS_W + K_W)'(eff_n);

	always_comb begin
		push_cmd.start = start_req;
		if (enum_mode) begin
			if (!start_req) begin
				push_cmd.op = OP_ENUM_NEXT;
			end else if (k_over_n) begin
				push_cmd.op = OP_ENUM_EMPTY;
			end else begin
				push_cmd.op = OP_ENUM_START;
			end
		end else if (eff_n == PTS_W'(1)) begin
			push_cmd.op = OP_RAND_ONE;
		end else if (PTS_W'(candidate) >= eff_n) begin
			push_cmd.op = OP_RAND_DROP;
		end else begin
			push_cmd.op = OP_RAND_CAND;
		end
	end

endmodule

>>> hw/rtl/sis_queue.sv
// Two-entry command queue between the front end and the back end.
module sis_queue #(
	parameter int DATA_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] push_data,
	output logic              full,
	input  logic              pop,
	output logic [DATA_W-1:0] pop_data,
	output logic              avail
);
	logic [DATA_W-1:0] entry_q [2];
	logic              wr_q;
	logic              rd_q;
	logic [1:0]        cnt_q;

	assign full     = cnt_q == 2'd2;
	assign avail    = cnt_q != 2'd0;
	assign pop_data = entry_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_data;
		end
	end

endmodule

>>> hw/rtl/sis_back.sv
// Back end: subset store, enumeration and duplicate scans, and the result register.
module sis_back #(
	parameter int MAX_POINTS = sis_pkg::SIS_MAX_POINTS,
	parameter int MAX_SUBSET = sis_pkg::SIS_MAX_SUBSET,
	localparam int PTS_W  = $clog2(MAX_POINTS + 1),
	localparam int CAND_W = $clog2(MAX_POINTS),
	localparam int K_W    = $clog2(MAX_SUBSET + 1),
	localparam int AW     = (MAX_SUBSET > 1) ? $clog2(MAX_SUBSET) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_avail,
	output logic                  cmd_pop,
	input  sis_pkg::cmd_t         cmd,
	input  logic [CAND_W-1:0]     cmd_cand,
	input  logic [PTS_W-1:0]      eff_n,
	input  logic [K_W-1:0]        eff_k,
	output logic                  result_valid,
	input  logic                  result_ready,
	output logic [PTS_W-1:0]      point_index,
	output logic [AW-1:0]         position,
	output logic                  last,
	output logic [sis_pkg::STS_W-1:0] status
);
	import sis_pkg::*;

	localparam int IDX_W = PTS_W;
	localparam int LIM_W = ((PTS_W > K_W) ? PTS_W : K_W) + 1;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SCAN_E = 3'd1;
	localparam logic [2:0] ST_SCAN_R = 3'd2;
	localparam logic [2:0] ST_EMIT   = 3'd3;
	localparam logic [2:0] ST_ONE    = 3'd4;

	localparam logic [1:0] EM_START = 2'd0;
	localparam logic [1:0] EM_NEXT  = 2'd1;
	localparam logic [1:0] EM_RAND  = 2'd2;

	logic [IDX_W-1:0]      store_q [MAX_SUBSET];
	logic [MAX_SUBSET-1:0] forced_q;
	logic [K_W-1:0]        filled_q;
	logic [REP_W-1:0]      rep_q;
	logic [2:0]            state_q;
	logic [1:0]            mode_q;
	logic [K_W-1:0]        j_q;
	logic [AW-1:0]         idx_q;
	logic [AW-1:0]         pivot_q;
	logic [LIM_W-1:0]      lim_q;
	logic [IDX_W-1:0]      run_q;
	logic [CAND_W-1:0]     cand_q;
	logic                  dup_q;
	logic [STS_W-1:0]      sts_q;

	logic                  result_valid_q;
	logic [PTS_W-1:0]      point_index_q;
	logic [AW-1:0]         position_q;
	logic                  last_q;
	logic [STS_W-1:0]      status_q;

	logic [AW-1:0]         rd_addr;
	logic [IDX_W-1:0]      rd_data;
	logic [IDX_W:0]        rplus;
	logic                  blocked;
	logic                  out_free;
	logic                  pre_clear;
	logic [REP_W-1:0]      rep_base;
	logic [REP_W-1:0]      rep_inc;
	logic                  scan_done;
	logic                  hit;
	logic                  fresh;
	logic                  force_in;
	logic                  take;
	logic [K_W-1:0]        fill_next;
	logic [IDX_W-1:0]      emit_val;
	logic                  emit_wr;
	logic                  emit_last;
	logic [STS_W-1:0]      emit_sts;
	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	logic [IDX_W-1:0]      wr_data;

	assign result_valid = result_valid_q;
	assign point_index  = point_index_q;
	assign position     = position_q;
	assign last         = last_q;
	assign status       = status_q;

	assign out_free = !result_valid_q || result_ready;
	assign cmd_pop  = (state_q == ST_IDLE) && cmd_avail;

	// One read port on the store: the enumeration scan walks idx_q, everything else j_q.
	assign rd_addr = (state_q == ST_SCAN_E) ? idx_q : j_q[AW-1:0];
	assign rd_data = store_q[rd_addr];

	// A slot cannot advance when its value plus one reaches its limit; a limit that
	// went below zero never blocks.
	assign rplus   = {1'b0, rd_data} + (IDX_W + 1)'(1);
	assign blocked = !lim_q[LIM_W-1] && (LIM_W'(rplus) >= lim_q);

	assign pre_clear = cmd.start || (filled_q >= eff_k);
	assign rep_base  = pre_clear ? '0 : rep_q;
	assign rep_inc   = (rep_base < REPEAT_SAT) ? rep_base + REP_W'(1) : rep_base;

	assign scan_done = j_q == filled_q;
	assign hit       = rd_data == IDX_W'(cand_q);
	assign fresh     = !dup_q;
	assign force_in  = dup_q && (rep_q > REPEAT_LIMIT);
	assign take      = fresh || force_in;
	assign fill_next = filled_q + K_W'(take);

	always_comb begin
		case (mode_q)
			EM_START: emit_val = IDX_W'(j_q);
			EM_NEXT:  emit_val = (j_q < K_W'(pivot_q)) ? rd_data : run_q;
			default:  emit_val = rd_data;
		endcase
	end

	assign emit_wr   = (mode_q == EM_START) || ((mode_q == EM_NEXT) && (j_q >= K_W'(pivot_q)));
	assign emit_last = (j_q + K_W'(1)) == eff_k;
	assign emit_sts  = ((mode_q == EM_RAND) && forced_q[j_q[AW-1:0]]) ? STS_FORCED : STS_NORMAL;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		if (cmd_pop && (cmd.op == OP_RAND_ONE)) begin
			wr_en = 1'b1;
		end else if ((state_q == ST_EMIT) && out_free && emit_wr) begin
			wr_en   = 1'b1;
			wr_addr = j_q[AW-1:0];
			wr_data = emit_val;
		end else if ((state_q == ST_SCAN_R) && scan_done && take) begin
			wr_en   = 1'b1;
			wr_addr = filled_q[AW-1:0];
			wr_data = fresh ? IDX_W'(cand_q) : IDX_W'(cand_q) + IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			forced_q       <= '0;
			filled_q       <= '0;
			rep_q          <= '0;
			mode_q         <= EM_START;
			j_q            <= '0;
			idx_q          <= '0;
			pivot_q        <= '0;
			lim_q          <= '0;
			run_q          <= '0;
			cand_q         <= '0;
			dup_q          <= 1'b0;
			sts_q          <= STS_NORMAL;
			result_valid_q <= 1'b0;
		end else begin
			if (result_ready) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_avail) begin
						case (cmd.op)
							OP_ENUM_START: begin
								rep_q    <= '0;
								forced_q <= '0;
								filled_q <= eff_k;
								mode_q   <= EM_START;
								j_q      <= '0;
								state_q  <= ST_EMIT;
							end
							OP_ENUM_EMPTY: begin
								rep_q    <= '0;
								forced_q <= '0;
								filled_q <= '0;
								sts_q    <= STS_EXHAUSTED;
								state_q  <= ST_ONE;
							end
							OP_ENUM_NEXT: begin
								rep_q    <= '0;
								forced_q <= '0;
								if (filled_q != eff_k) begin
									sts_q   <= STS_EXHAUSTED;
									state_q <= ST_ONE;
								end else begin
									idx_q   <= AW'(eff_k - K_W'(1));
									lim_q   <= LIM_W'(eff_n);
									state_q <= ST_SCAN_E;
								end
							end
							OP_RAND_ONE: begin
								rep_q    <= '0;
								forced_q <= '0;
								filled_q <= '0;
								sts_q    <= STS_NORMAL;
								state_q  <= ST_ONE;
							end
							OP_RAND_DROP: begin
								if (pre_clear) begin
									rep_q    <= '0;
									forced_q <= '0;
									filled_q <= '0;
								end
							end
							OP_RAND_CAND: begin
								if (pre_clear) begin
									forced_q <= '0;
									filled_q <= '0;
								end
								rep_q   <= rep_inc;
								cand_q  <= cmd_cand;
								j_q     <= '0;
								dup_q   <= 1'b0;
								state_q <= ST_SCAN_R;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_SCAN_E: begin
					if (!blocked) begin
						pivot_q <= idx_q;
						run_q   <= rplus[IDX_W-1:0];
						mode_q  <= EM_NEXT;
						j_q     <= '0;
						state_q <= ST_EMIT;
					end else if (idx_q == '0) begin
						sts_q   <= STS_EXHAUSTED;
						state_q <= ST_ONE;
					end else begin
						idx_q <= idx_q - AW'(1);
						lim_q <= lim_q - LIM_W'(1);
					end
				end
				ST_SCAN_R: begin
					if (!scan_done) begin
						dup_q <= dup_q || hit;
						j_q   <= j_q + K_W'(1);
					end else begin
						if (take) begin
							forced_q[filled_q[AW-1:0]] <= force_in;
							filled_q                   <= fill_next;
						end
						if (fresh) begin
							rep_q <= '0;
						end
						if (fill_next >= eff_k) begin
							mode_q  <= EM_RAND;
							j_q     <= '0;
							state_q <= ST_EMIT;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						result_valid_q <= 1'b1;
						if (emit_wr && (mode_q == EM_NEXT)) begin
							run_q <= run_q + IDX_W'(1);
						end
						j_q <= j_q + K_W'(1);
						if (emit_last) begin
							state_q <= ST_IDLE;
							if (mode_q == EM_RAND) begin
								filled_q <= '0;
								rep_q    <= '0;
								forced_q <= '0;
							end
						end
					end
				end
				ST_ONE: begin
					if (out_free) begin
						result_valid_q <= 1'b1;
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_EMIT) && out_free) begin
			point_index_q <= emit_val;
			position_q    <= j_q[AW-1:0];
			last_q        <= emit_last;
			status_q      <= emit_sts;
		end else if ((state_q == ST_ONE) && out_free) begin
			point_index_q <= '0;
			position_q    <= '0;
			last_q        <= 1'b1;
			status_q      <= sts_q;
		end
	end

endmodule

>>> hw/rtl/subset_index_sampler.sv
// Top level of the subset index sampler: configuration registers, front end, queue, back end.
//
// The sampler hands out subsets of subset_size point indices drawn from 0..num_points-1.
// With enumerate_all set, a beat with start_req gives indices 0..k-1 (or a single exhausted
// result when k exceeds the point count) and every other beat gives the next k-subset in
// lexicographic order; once the last subset has gone out, or when no subset is held (no
// start yet, k changed, or a random-mode beat came in between), a beat gives a single result
// with status exhausted. With enumerate_all clear, each beat offers a candidate index:
// out-of-range candidates are dropped, duplicates are rejected until more than 100 in-range
// candidates have come in without progress, after which a duplicate is entered as candidate
// plus one and marked forced; when the subset is full it goes out as k result beats, the
// last one flagged. In this mode a single-point configuration gives index 0 on every beat.
// Flow: the front end classifies a beat in the cycle it is accepted and drops it into a
// two-entry queue, so input beats keep flowing while the back end works or the result side
// stalls, until the queue fills. The back end owns a subset store with one read port and
// takes one command at a time: an enumeration step is dispatched, scans from the right for
// the slot to advance, and sends its k results; a random beat is dispatched, scans the held
// indices for a duplicate, decides, and sends k results when it completes the subset. The
// one-deep result register lets the back end finish a beat while the previous result still
// waits. Configuration writes are registered and must only be issued while the block is idle.
module subset_index_sampler #(
	parameter int MAX_POINTS = sis_pkg::SIS_MAX_POINTS,
	parameter int MAX_SUBSET = sis_pkg::SIS_MAX_SUBSET,
	localparam int PTS_W  = $clog2(MAX_POINTS + 1),
	localparam int CAND_W = $clog2(MAX_POINTS),
	localparam int K_W    = $clog2(MAX_SUBSET + 1),
	localparam int AW     = (MAX_SUBSET > 1) ? $clog2(MAX_SUBSET) : 1,
	localparam int CFG_W  = (PTS_W > K_W) ? PTS_W : K_W
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [sis_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]              cfg_data,
	input  logic                          item_valid,
	output logic                          item_ready,
	input  logic                          start_req,
	input  logic [CAND_W-1:0]             candidate,
	output logic                          result_valid,
	input  logic                          result_ready,
	output logic [PTS_W-1:0]              point_index,
	output logic [AW-1:0]                 position,
	output logic                          last,
	output logic [sis_pkg::STS_W-1:0]     status
);
	import sis_pkg::*;

	localparam int Q_W = $bits(cmd_t) + CAND_W;

	logic              enum_q;
	logic [PTS_W-1:0]  npts_q;
	logic [K_W-1:0]    ksz_q;
	logic [PTS_W-1:0]  eff_n;
	logic [K_W-1:0]    eff_k;

	logic              q_full;
	logic              q_push;
	cmd_t              f_cmd;
	logic [CAND_W-1:0] f_cand;
	logic [Q_W-1:0]    q_out;
	logic              q_avail;
	logic              q_pop;
	cmd_t              b_cmd;
	logic [CAND_W-1:0] b_cand;

	// Configuration registers; out-of-range values are clamped below, not at write time.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enum_q <= 1'b0;
			npts_q <= PTS_W'(1);
			ksz_q  <= K_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ENUMERATE:   enum_q <= cfg_data[0];
				CFG_NUM_POINTS:  npts_q <= cfg_data[PTS_W-1:0];
				CFG_SUBSET_SIZE: ksz_q  <= cfg_data[K_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Zero acts as one, and anything above the maximum acts as the maximum.
	always_comb begin
		if (npts_q == '0) begin
			eff_n = PTS_W'(1);
		end else if (npts_q > PTS_W'(MAX_POINTS)) begin
			eff_n = PTS_W'(MAX_POINTS);
		end else begin
			eff_n = npts_q;
		end
		if (ksz_q == '0) begin
			eff_k = K_W'(1);
		end else if (ksz_q > K_W'(MAX_SUBSET)) begin
			eff_k = K_W'(MAX_SUBSET);
		end else begin
			eff_k = ksz_q;
		end
	end

	sis_front #(
		.MAX_POINTS (MAX_POINTS),
		.MAX_SUBSET (MAX_SUBSET)
	) u_front (
		.item_valid (item_valid),
		.item_ready (item_ready),
		.start_req  (start_req),
		.candidate  (candidate),
		.enum_mode  (enum_q),
		.eff_n      (eff_n),
		.eff_k      (eff_k),
		.q_full     (q_full),
		.push       (q_push),
		.push_cmd   (f_cmd),
		.push_cand  (f_cand)
	);

	sis_queue #(
		.DATA_W (Q_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data ({f_cmd, f_cand}),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_out),
		.avail     (q_avail)
	);

	assign b_cmd  = cmd_t'(q_out[Q_W-1:CAND_W]);
	assign b_cand = q_out[CAND_W-1:0];

	sis_back #(
		.MAX_POINTS (MAX_POINTS),
		.MAX_SUBSET (MAX_SUBSET)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_avail    (q_avail),
		.cmd_pop      (q_pop),
		.cmd          (b_cmd),
		.cmd_cand     (b_cand),
		.eff_n        (eff_n),
		.eff_k        (eff_k),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.point_index  (point_index),
		.position     (position),
		.last         (last),
		.status       (status)
	);

endmodule

>>> hw/rtl/sis_checker.sv
// Port-level checks for the subset index sampler, bound to the top level.
module sis_checker #(
	parameter int MAX_POINTS = sis_pkg::SIS_MAX_POINTS,
	parameter int MAX_SUBSET = sis_pkg::SIS_MAX_SUBSET,
	localparam int PTS_W = $clog2(MAX_POINTS + 1),
	localparam int AW    = (MAX_SUBSET > 1) ? $clog2(MAX_SUBSET) : 1
) (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      result_valid,
	input logic                      result_ready,
	input logic [PTS_W-1:0]          point_index,
	input logic [AW-1:0]             position,
	input logic                      last,
	input logic [sis_pkg::STS_W-1:0] status
);
	import sis_pkg::*;

	// A stalled result beat holds its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(point_index)
			&& $stable(position) && $stable(last) && $stable(status))
		else $error("result beat changed while stalled");

	// The result register is empty while reset is applied.
	a_reset: assert property (@(posedge clk) !arst_n |-> !result_valid)
		else $error("result valid during reset");

	// An exhausted beat is the lone beat of its item: index 0, slot 0, flagged last.
	a_exh: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (status == STS_EXHAUSTED) |-> last && (point_index == '0)
			&& (position == '0))
		else $error("malformed exhausted beat");

	// Right after a beat that is not last, the next beat cannot restart at slot 0.
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_ready && !last |=> !(result_valid && (position == '0)))
		else $error("subset restarted before its last beat");

endmodule

bind subset_index_sampler sis_checker #(
	.MAX_POINTS (MAX_POINTS),
	.MAX_SUBSET (MAX_SUBSET)
) u_sis_checker (.*);

>>> sim/tb_subset_index_sampler.sv
// Self-checking testbench for the subset index sampler: directed table, random phases, scoreboard.
module tb_subset_index_sampler;
	import sis_pkg::*;

	localparam int PTS_W  = 13;
	localparam int CAND_W = 12;
	localparam int AW     = 3;
	localparam int CFG_W  = 13;

	// Cycles allowed after the last expected beat for beats that give no result.
	localparam int SETTLE_CYCLES = 64;
	// Hard stop of the run, far above the slowest legal run.
	localparam int CYCLE_LIMIT = 500000;
	localparam int BEAT_TARGET = 410;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 item_valid;
	logic                 item_ready;
	logic                 start_req;
	logic [CAND_W-1:0]    candidate;
	logic                 result_valid;
	logic                 result_ready;
	logic [PTS_W-1:0]     point_index;
	logic [AW-1:0]        position;
	logic                 last;
	logic [STS_W-1:0]     status;

	subset_index_sampler DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.start_req    (start_req),
		.candidate    (candidate),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.point_index  (point_index),
		.position     (position),
		.last         (last),
		.status       (status)
	);

	// One result beat as it leaves the block.
	typedef struct packed {
		logic [PTS_W-1:0] pidx;
		logic [AW-1:0]    pos;
		logic             last;
		logic [STS_W-1:0] sts;
	} subset_beat_t;

	// A row of the directed table is either a register write or an input beat. Beat rows
	// with a typed answer carry the single result beat that they must give.
	typedef enum logic {ROW_WRITE, ROW_BEAT} row_kind_e;

	typedef struct packed {
		row_kind_e            kind;
		logic [CFG_IDX_W-1:0] reg_sel;
		logic [CFG_W-1:0]     value;
		logic                 st;
		logic [CAND_W-1:0]    cd;
		logic                 typed;
		subset_beat_t         want;
	} stim_row_t;

	localparam int N_DIRECTED_ROWS = 38;
	stim_row_t directed_rows [N_DIRECTED_ROWS];

	// Shadow of the configuration registers and of the sampler state.
	logic             cfg_enum;
	logic [CFG_W-1:0] cfg_pts;
	logic [3:0]       cfg_k;
	logic [PTS_W-1:0] held_idx [8];
	bit               forced_slot [8];
	int unsigned      held_cnt;
	int unsigned      miss_run;

	subset_beat_t step_beats[$];        // results of the beat just predicted
	subset_beat_t subset_beats_due[$];  // results still owed by the block, oldest first

	int unsigned beats_sent;
	int unsigned mismatches;
	int unsigned cycle_count;
	int unsigned tx_idle_pct;
	int unsigned rx_idle_pct;
	int unsigned rx_hold_req;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic flag_error(input string msg);
		$display("MISMATCH @%0t: %s", $time, msg);
		mismatches++;
	endtask

	function automatic int unsigned points_in_use();
		if (cfg_pts == 0) return 1;
		if (cfg_pts > SIS_MAX_POINTS) return SIS_MAX_POINTS;
		return cfg_pts;
	endfunction

	function automatic int unsigned size_in_use();
		if (cfg_k == 0) return 1;
		if (cfg_k > SIS_MAX_SUBSET) return SIS_MAX_SUBSET;
		return cfg_k;
	endfunction

	function automatic void clear_progress();
		miss_run = 0;
		foreach (forced_slot[j]) forced_slot[j] = 1'b0;
	endfunction

	function automatic void give_subset(input int unsigned k);
		for (int unsigned j = 0; j < k; j++)
			step_beats.push_back(subset_beat_t'{held_idx[j], 3'(j), 1'(j + 1 == k),
				forced_slot[j] ? STS_FORCED : STS_NORMAL});
	endfunction

	function automatic void give_exhausted();
		step_beats.push_back(subset_beat_t'{13'd0, 3'd0, 1'b1, STS_EXHAUSTED});
	endfunction

	// Works out the result beats of one accepted input beat into step_beats and moves the
	// shadow state on, exactly as the sampler must.
	function automatic void sample_next(input logic st, input logic [CAND_W-1:0] cd);
		int unsigned n;
		int unsigned k;
		int unsigned i;
		int unsigned lim;
		bit dup;
		n = points_in_use();
		k = size_in_use();
		dup = 1'b0;
		step_beats.delete();
		if (cfg_enum) begin
			clear_progress();
			if (st) begin
				if (k > n) begin
					held_cnt = 0;
					give_exhausted();
				end else begin
					for (int unsigned j = 0; j < k; j++) held_idx[j] = 13'(j);
					held_cnt = k;
					give_subset(k);
				end
			end else if (held_cnt != k) begin
				give_exhausted();
			end else begin
				// Walk left to the rightmost slot that still has room to grow; the limit
				// shrinks by one per slot, and wraps like an unsigned counter.
				i = k;
				lim = n;
				while (i > 0 && held_idx[i - 1] + 1 >= lim) begin
					i--;
					lim--;
				end
				if (i == 0) begin
					give_exhausted();
				end else begin
					i--;
					held_idx[i] = held_idx[i] + 13'd1;
					for (int unsigned j = i + 1; j < k; j++) held_idx[j] = held_idx[j - 1] + 13'd1;
					give_subset(k);
				end
			end
		end else begin
			if (st || held_cnt >= k) begin
				held_cnt = 0;
				clear_progress();
			end
			if (n == 1) begin
				held_cnt = 0;
				clear_progress();
				held_idx[0] = '0;
				step_beats.push_back(subset_beat_t'{13'd0, 3'd0, 1'b1, STS_NORMAL});
			end else if (cd < n) begin
				if (miss_run < REPEAT_SAT) miss_run++;
				for (int unsigned j = 0; j < held_cnt && j < 8; j++)
					if (held_idx[j] == cd) dup = 1'b1;
				if (!dup) begin
					held_idx[held_cnt] = cd;
					forced_slot[held_cnt] = 1'b0;
					held_cnt++;
					miss_run = 0;
				end else if (miss_run > REPEAT_LIMIT) begin
					// Too long without progress: the neighbor index goes in, marked forced.
					held_idx[held_cnt] = cd + 13'd1;
					forced_slot[held_cnt] = 1'b1;
					held_cnt++;
				end
				if (held_cnt >= k) begin
					give_subset(k);
					held_cnt = 0;
					clear_progress();
				end
			end
		end
	endfunction

	function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] sel, input int unsigned v);
		stim_row_t row;
		row = '0;
		row.kind = ROW_WRITE;
		row.reg_sel = sel;
		row.value = v[CFG_W-1:0];
		return row;
	endfunction

	function automatic stim_row_t beat_row(input logic st, input int unsigned cd);
		stim_row_t row;
		row = '0;
		row.kind = ROW_BEAT;
		row.st = st;
		row.cd = cd[CAND_W-1:0];
		return row;
	endfunction

	// A beat whose single result is plain to see: index at slot 0, flagged last.
	function automatic stim_row_t known_row(input logic st, input int unsigned cd,
			input int unsigned pidx, input logic [STS_W-1:0] sts);
		stim_row_t row;
		row = beat_row(st, cd);
		row.typed = 1'b1;
		row.want = subset_beat_t'{pidx[PTS_W-1:0], 3'd0, 1'b1, sts};
		return row;
	endfunction

	// Register writes land at the rising edge; the shadow copy follows at the same edge.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] sel, input int unsigned v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= sel;
		cfg_data <= v[CFG_W-1:0];
		@(posedge clk);
		case (sel)
			CFG_ENUMERATE:   cfg_enum = v[0];
			CFG_NUM_POINTS:  cfg_pts = v[CFG_W-1:0];
			CFG_SUBSET_SIZE: cfg_k = v[3:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Offers one input beat, holds it until accepted, then books its expected results.
	// The idle mix follows the progress of the run: sender rarely idle and receiver mostly
	// idle first, then the reverse, then full speed on both sides.
	task automatic send_beat(input logic st, input logic [CAND_W-1:0] cd, input logic typed,
			input subset_beat_t want);
		if (beats_sent < 140) begin
			tx_idle_pct = 9;
			rx_idle_pct = 66;
		end else if (beats_sent < 280) begin
			tx_idle_pct = 66;
			rx_idle_pct = 9;
		end else begin
			tx_idle_pct = 0;
			rx_idle_pct = 0;
		end
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		start_req <= st;
		candidate <= cd;
		@(posedge clk);
		while (item_ready !== 1'b1) @(posedge clk);
		beats_sent++;
		sample_next(st, cd);
		if (typed) begin
			subset_beats_due.push_back(want);
		end else begin
			foreach (step_beats[i]) subset_beats_due.push_back(step_beats[i]);
		end
	endtask

	// Brings the block to rest: no beat offered, every owed result out, and enough extra
	// cycles for queued beats that give no result to pass through the back end.
	task automatic drain();
		@(negedge clk);
		item_valid <= 1'b0;
		while (subset_beats_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Result side: random back-pressure, plus a long hold-off when the stimulus asks for one.
	initial begin : result_sink
		int unsigned hold;
		hold = 0;
		result_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_req != 0) begin
				hold = rx_hold_req;
				rx_hold_req = 0;
			end
			if (hold != 0) begin
				hold--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// Scoreboard: every accepted result beat against the oldest one owed.
	always @(posedge clk) begin : check_results
		subset_beat_t want;
		if (arst_n && result_valid === 1'b1 && result_ready === 1'b1) begin
			if (subset_beats_due.size() == 0) begin
				flag_error($sformatf("result beat with none owed: index %0d pos %0d status %0d",
					point_index, position, status));
			end else begin
				want = subset_beats_due.pop_front();
				if (point_index !== want.pidx)
					flag_error($sformatf("point_index %0d, want %0d", point_index, want.pidx));
				if (position !== want.pos)
					flag_error($sformatf("position %0d, want %0d", position, want.pos));
				if (last !== want.last)
					flag_error($sformatf("last %0b, want %0b", last, want.last));
				if (status !== want.sts)
					flag_error($sformatf("status %0d, want %0d", status, want.sts));
			end
		end
	end

	// Watchdog: a hang anywhere ends the run as a failure.
	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	initial begin : stimulus
		int unsigned r;
		int unsigned k_set;
		int unsigned kk;
		int unsigned n_set;
		int unsigned n_eff;
		int unsigned n_beats;
		int unsigned b;
		logic mode_enum;
		logic st;
		logic [CAND_W-1:0] cd;
		logic in_flight;
		bit stuck_done;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		item_valid = 1'b0;
		start_req = 1'b0;
		candidate = '0;
		rx_hold_req = 0;
		tx_idle_pct = 9;
		rx_idle_pct = 66;
		beats_sent = 0;
		mismatches = 0;
		in_flight = 1'b0;
		stuck_done = 1'b0;

		// Shadow state after reset.
		cfg_enum = 1'b0;
		cfg_pts = 13'd1;
		cfg_k = 4'd1;
		held_cnt = 0;
		foreach (held_idx[j]) held_idx[j] = '0;
		clear_progress();

		directed_rows = '{
			// Reset values: one point, so every beat gives index 0 whatever the candidate.
			known_row(1'b0, 0, 0, STS_NORMAL),
			known_row(1'b1, 4095, 0, STS_NORMAL),
			// A point count of zero behaves as one point.
			cfg_row(CFG_NUM_POINTS, 0),
			known_row(1'b0, 5, 0, STS_NORMAL),
			// Oversized registers clamp: 4096 points, and size zero behaves as one.
			cfg_row(CFG_NUM_POINTS, 8191),
			cfg_row(CFG_SUBSET_SIZE, 0),
			known_row(1'b0, 4095, 4095, STS_NORMAL),
			known_row(1'b1, 0, 0, STS_NORMAL),
			// Size above the maximum clamps to eight; build one random subset of ten points
			// with an out-of-range candidate and a duplicate on the way.
			cfg_row(CFG_SUBSET_SIZE, 15),
			cfg_row(CFG_NUM_POINTS, 10),
			beat_row(1'b1, 12),
			beat_row(1'b0, 3),
			beat_row(1'b0, 3),
			beat_row(1'b0, 9),
			beat_row(1'b0, 0),
			beat_row(1'b0, 5),
			beat_row(1'b0, 1),
			beat_row(1'b0, 2),
			beat_row(1'b0, 7),
			beat_row(1'b0, 4),
			// Enumerate three of four: no subset held yet, then the full walk to exhaustion
			// and one more beat after it.
			cfg_row(CFG_ENUMERATE, 1),
			cfg_row(CFG_NUM_POINTS, 4),
			cfg_row(CFG_SUBSET_SIZE, 3),
			known_row(1'b0, 0, 0, STS_EXHAUSTED),
			beat_row(1'b1, 4095),
			beat_row(1'b0, 0),
			beat_row(1'b0, 0),
			beat_row(1'b0, 0),
			known_row(1'b0, 0, 0, STS_EXHAUSTED),
			known_row(1'b0, 0, 0, STS_EXHAUSTED),
			// Subset larger than the point count: a start is exhausted at once.
			cfg_row(CFG_SUBSET_SIZE, 5),
			known_row(1'b1, 0, 0, STS_EXHAUSTED),
			// Largest sizes, then a size change that drops the held subset.
			cfg_row(CFG_SUBSET_SIZE, 8),
			cfg_row(CFG_NUM_POINTS, 4096),
			beat_row(1'b1, 0),
			beat_row(1'b0, 0),
			cfg_row(CFG_SUBSET_SIZE, 2),
			known_row(1'b0, 0, 0, STS_EXHAUSTED)
		};

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_WRITE) begin
				if (in_flight) drain();
				in_flight = 1'b0;
				write_reg(directed_rows[i].reg_sel, directed_rows[i].value);
			end else begin
				send_beat(directed_rows[i].st, directed_rows[i].cd, directed_rows[i].typed,
					directed_rows[i].want);
				in_flight = 1'b1;
			end
		end
		drain();

		// Back-pressure: the receiver holds off while eight-index subsets keep coming, so the
		// result register and the input queue fill and item_ready drops.
		write_reg(CFG_ENUMERATE, 1);
		write_reg(CFG_NUM_POINTS, 12);
		write_reg(CFG_SUBSET_SIZE, 8);
		rx_hold_req = 400;
		for (b = 0; b < 16; b++) send_beat(b == 0, CAND_W'($urandom), 1'b0, '0);
		drain();

		while (beats_sent < BEAT_TARGET) begin
			if (!stuck_done && beats_sent >= 180) begin
				// Repeat limit: two fresh indices, then a hundred duplicates. The next
				// duplicate of 4095 is forced in as 4096, and since the miss count is not
				// cleared by a forced entry, the duplicate after it is forced as well.
				stuck_done = 1'b1;
				write_reg(CFG_ENUMERATE, 0);
				write_reg(CFG_NUM_POINTS, 4096);
				write_reg(CFG_SUBSET_SIZE, 4);
				send_beat(1'b1, 12'd4095, 1'b0, '0);
				send_beat(1'b0, 12'd0, 1'b0, '0);
				for (b = 0; b < 100; b++)
					send_beat(1'b0, $urandom_range(1) ? 12'd4095 : 12'd0, 1'b0, '0);
				send_beat(1'b0, 12'd4095, 1'b0, '0);
				send_beat(1'b0, 12'd0, 1'b0, '0);
			end else begin
				// One phase of random settings. Apart from point counts of zero and one, random-mode
				// point counts stay above the subset size, so that most subsets complete without the repeat limit.
				mode_enum = $urandom_range(1);
				k_set = ($urandom_range(7) == 0) ? $urandom_range(15) : $urandom_range(1, 8);
				kk = (k_set == 0) ? 1 : ((k_set > 8) ? 8 : k_set);
				r = $urandom_range(99);
				if (r < 8) n_set = $urandom_range(1);
				else if (r < 18) n_set = $urandom_range(4096, 8191);
				else if (mode_enum) n_set = $urandom_range(1, 12);
				else if (r < 55) n_set = $urandom_range(kk + 1, kk + 8);
				else n_set = $urandom_range(kk + 8, 4096);
				write_reg(CFG_ENUMERATE, mode_enum);
				write_reg(CFG_NUM_POINTS, n_set);
				write_reg(CFG_SUBSET_SIZE, k_set);
				n_eff = points_in_use();
				n_beats = mode_enum ? $urandom_range(6, 18) : $urandom_range(8, 30);
				for (b = 0; b < n_beats; b++) begin
					if (mode_enum) st = (b == 0) ? ($urandom_range(3) != 0) : ($urandom_range(11) == 0);
					else st = ($urandom_range(19) == 0);
					// Mostly in-range candidates; the rest span the whole field.
					if ($urandom_range(99) < 85) cd = CAND_W'($urandom_range(n_eff - 1));
					else cd = CAND_W'($urandom);
					send_beat(st, cd, 1'b0, '0);
				end
			end
			drain();
		end

		if (mismatches == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
